// File: hw/rtl/nekq_pkg.sv
// Package for the nearby edge key quantizer.
// Holds the payload structs, widths and constants; depends on nothing.
package nekq_pkg;

    localparam int COORD_BITS = 32;
    localparam int CELL_BITS  = 24;
    localparam int TOL_BITS   = COORD_BITS - 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int CMP_BITS   = TOL_BITS + CELL_BITS + 1;
    localparam int SIDE_BITS  = 2;
    localparam int SOUT_BITS  = 3;
    localparam int LANES      = 6;

    localparam logic [SOUT_BITS-1:0] SIDE_SWAP = 3'd3;

    typedef enum logic [1:0] {
        REG_MIN_X     = 2'd0,
        REG_MIN_Y     = 2'd1,
        REG_MIN_Z     = 2'd2,
        REG_TOLERANCE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic [SIDE_BITS-1:0]         edge_side;
    } edge_in_t;

    typedef struct packed {
        logic                 edge_valid;
        logic [CELL_BITS-1:0] first_cell_x;
        logic [CELL_BITS-1:0] first_cell_y;
        logic [CELL_BITS-1:0] first_cell_z;
        logic [CELL_BITS-1:0] second_cell_x;
        logic [CELL_BITS-1:0] second_cell_y;
        logic [CELL_BITS-1:0] second_cell_z;
        logic [SOUT_BITS-1:0] side_out;
    } edge_key_t;

    // Lanes 0..2 carry vertex a (x, y, z), lanes 3..5 carry vertex b.
    typedef struct packed {
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0]                 sat;
        logic [LANES-1:0][COORD_BITS-1:0] rem;
        logic [LANES-1:0][CELL_BITS-1:0]  quo;
        logic [2:0][DIFF_BITS-1:0]        absd;
        logic [2:0]                       gt;
        logic                             a_first;
        logic [SIDE_BITS-1:0]             side;
    } work_t;

endpackage

// File: hw/rtl/nearby_edge_key_quantizer.sv
// Top level of the nearby edge key quantizer: a fully pipelined grid
// quantizer and key builder. Depends on nekq_pkg.
//
// One edge beat is accepted every cycle while key_ready does not hold back
// the pipeline. The depth is set by the restoring dividers, which retire one
// quotient bit per stage for all six coordinates in parallel. Two front
// stages form the offsets, the axis choice and the saturation test, and the
// output register closes the chain. Each stage holds its beat only while
// the one after it is full and stalled, so bubbles are squeezed out.
// Configuration writes are taken at once and must only be made while the
// pipeline is empty.
module nearby_edge_key_quantizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_ready,
    input  nekq_pkg::edge_in_t            src_data,
    output logic                          key_valid,
    input  logic                          key_ready,
    output nekq_pkg::edge_key_t           key_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [nekq_pkg::COORD_BITS-1:0] cfg_data
);
    import nekq_pkg::*;

    localparam int NSTG = CELL_BITS + 2;

    logic signed [COORD_BITS-1:0] min_reg [3];
    logic [TOL_BITS-1:0]          tol_reg;

    work_t       pipe_reg  [NSTG];
    work_t       pipe_next [NSTG];
    logic [NSTG:0] vld_reg;
    logic [NSTG:0] adv;
    edge_key_t   key_reg;
    edge_key_t   key_next;

    assign cfg_ready = 1'b1;
    assign src_ready = adv[0];
    assign key_valid = vld_reg[NSTG];
    assign key_data  = key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg[0] <= '0;
            min_reg[1] <= '0;
            min_reg[2] <= '0;
            tol_reg    <= TOL_BITS'(65536);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_X:     min_reg[0] <= cfg_data;
                REG_MIN_Y:     min_reg[1] <= cfg_data;
                REG_MIN_Z:     min_reg[2] <= cfg_data;
                REG_TOLERANCE:
                begin
                    // A zero cell size behaves as the smallest one.
                    if (cfg_data[TOL_BITS-1:0] == '0)
                        tol_reg <= TOL_BITS'(1);
                    else
                        tol_reg <= cfg_data[TOL_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    // Stall chain: a stage loads when empty or when its successor loads.
    always_comb
    begin
        adv[NSTG] = !vld_reg[NSTG] || key_ready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        logic signed [COORD_BITS-1:0] ca [3];
        logic signed [COORD_BITS-1:0] cb [3];
        logic signed [DIFF_BITS-1:0]  dif;
        logic signed [DIFF_BITS-1:0]  dab;
        logic [CMP_BITS-1:0]          lim;
        work_t                        w;
        ca[0] = src_data.a_x;
        ca[1] = src_data.a_y;
        ca[2] = src_data.a_z;
        cb[0] = src_data.b_x;
        cb[1] = src_data.b_y;
        cb[2] = src_data.b_z;

        // Stage 0: offsets from the minimum and per-axis spans.
        w = '0;
        w.side = src_data.edge_side;
        for (int i = 0; i < 3; i++)
        begin
            dif = DIFF_BITS'(ca[i]) - DIFF_BITS'(min_reg[i]);
            w.neg[i] = dif[DIFF_BITS-1];
            w.rem[i] = dif[COORD_BITS-1:0];
            dif = DIFF_BITS'(cb[i]) - DIFF_BITS'(min_reg[i]);
            w.neg[i+3] = dif[DIFF_BITS-1];
            w.rem[i+3] = dif[COORD_BITS-1:0];
            dab = DIFF_BITS'(ca[i]) - DIFF_BITS'(cb[i]);
            w.absd[i] = dab[DIFF_BITS-1] ? -dab : dab;
            w.gt[i]   = !dab[DIFF_BITS-1] && (dab != '0);
        end
        pipe_next[0] = w;

        // Stage 1: saturation test and choice of the leading vertex.
        w = pipe_reg[0];
        lim = {1'b0, tol_reg, {CELL_BITS{1'b0}}};
        for (int l = 0; l < LANES; l++)
        begin
            w.sat[l] = CMP_BITS'(w.rem[l]) >= lim;
        end
        if (w.absd[0] >= w.absd[1] && w.absd[0] >= w.absd[2])
            w.a_first = w.gt[0];
        else if (w.absd[1] >= w.absd[2])
            w.a_first = w.gt[1];
        else
            w.a_first = w.gt[2];
        pipe_next[1] = w;

        // Division stages, most significant quotient bit first.
        for (int k = 2; k < NSTG; k++)
        begin
            w = pipe_reg[k-1];
            lim = CMP_BITS'(tol_reg) << (NSTG - 1 - k);
            for (int l = 0; l < LANES; l++)
            begin
                if (CMP_BITS'(w.rem[l]) >= lim)
                begin
                    w.rem[l] = w.rem[l] - lim[COORD_BITS-1:0];
                    w.quo[l][NSTG-1-k] = 1'b1;
                end
            end
            pipe_next[k] = w;
        end
    end

    always_comb
    begin
        logic [CELL_BITS-1:0] grid [LANES];
        work_t                w;
        w = pipe_reg[NSTG-1];
        for (int l = 0; l < LANES; l++)
        begin
            if (w.neg[l])
                grid[l] = '0;
            else if (w.sat[l])
                grid[l] = {CELL_BITS{1'b1}};
            else
                grid[l] = w.quo[l];
        end
        key_next = '0;
        if (grid[0] != grid[3] || grid[1] != grid[4] || grid[2] != grid[5])
        begin
            key_next.edge_valid = 1'b1;
            if (w.a_first)
            begin
                key_next.first_cell_x  = grid[0];
                key_next.first_cell_y  = grid[1];
                key_next.first_cell_z  = grid[2];
                key_next.second_cell_x = grid[3];
                key_next.second_cell_y = grid[4];
                key_next.second_cell_z = grid[5];
                key_next.side_out      = {1'b0, w.side};
            end
            else
            begin
                key_next.first_cell_x  = grid[3];
                key_next.first_cell_y  = grid[4];
                key_next.first_cell_z  = grid[5];
                key_next.second_cell_x = grid[0];
                key_next.second_cell_y = grid[1];
                key_next.second_cell_z = grid[2];
                key_next.side_out      = {1'b0, w.side} + SIDE_SWAP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
                vld_reg[0] <= src_valid;
            for (int k = 1; k <= NSTG; k++)
            begin
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (adv[k])
                pipe_reg[k] <= pipe_next[k];
        end
        if (adv[NSTG])
            key_reg <= key_next;
    end

`ifndef SYNTH
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_data.edge_valid |->
            key_data.side_out == '0 && key_data.first_cell_x == '0 &&
            key_data.second_cell_z == '0)
        else $error("degenerate key carries nonzero fields");
    a_cells_differ: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_data.edge_valid |->
            key_data.first_cell_x != key_data.second_cell_x ||
            key_data.first_cell_y != key_data.second_cell_y ||
            key_data.first_cell_z != key_data.second_cell_z)
        else $error("valid key has both vertices in one cell");
    a_tol_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> tol_reg != '0)
        else $error("cell size register holds zero");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG-1] && !adv[NSTG-1] |=> vld_reg[NSTG-1])
        else $error("stalled beat dropped in the last division stage");
`endif

endmodule
